[rtl/core/ces_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_pkg
// shared constants, command/status types and clamp helpers
// ----------------------------------------------------------------------------
package ces_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_FEATURES = 16;
    localparam int MAX_SELECT   = 64;
    localparam int SCORE_BITS   = 32;

    localparam int ROW_W   = $clog2(MAX_ROWS);                // 10
    localparam int ROWS_W  = ROW_W + 1;                       // 11
    localparam int FEAT_W  = $clog2(MAX_FEATURES);            // 4
    localparam int FEATS_W = FEAT_W + 1;                      // 5
    localparam int RANK_W  = $clog2(MAX_SELECT);              // 6
    localparam int SEL_W   = RANK_W + 1;                      // 7
    localparam int ADDR_W  = ROW_W + FEAT_W;                  // 14
    localparam int TOT_W   = ADDR_W + 1;                      // 15
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 2'd2;

    typedef logic signed [SCORE_BITS-1:0] t_score;

    typedef struct packed {
        logic clr_step;
        logic load_en;
        logic div_step;
        logic qfix;
        logic adv_phase;
        logic scan_start;
        logic scan_step;
        logic pick;
        logic undo_start;
        logic undo_step;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic last_acc;
        logic div_done;
        logic sel_done;
        logic phase_full;
        logic scan_done;
        logic out_busy;
        logic undo_done;
    } t_dp_stat;

    function automatic logic [ROWS_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [ROWS_W-1:0] r;
        if (v == '0) r = ROWS_W'(1);
        else if (v > CFG_W'(MAX_ROWS)) r = ROWS_W'(MAX_ROWS);
        else r = v[ROWS_W-1:0];
        return r;
    endfunction

    function automatic logic [FEATS_W-1:0] clamp_feats(input logic [FEATS_W-1:0] v);
        logic [FEATS_W-1:0] r;
        if (v == '0) r = FEATS_W'(1);
        else if (v > FEATS_W'(MAX_FEATURES)) r = FEATS_W'(MAX_FEATURES);
        else r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/ces_score_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_score_if
// input channel: one score value per item
// ----------------------------------------------------------------------------
interface ces_score_if;
    logic                 valid;
    logic                 ready;
    ces_pkg::t_score      score;

    modport source (output valid, output score, input ready);
    modport sink   (input valid, input score, output ready);
endinterface
`default_nettype wire

[rtl/core/ces_pick_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_pick_if
// output channel: one selected row per item
// ----------------------------------------------------------------------------
interface ces_pick_if;
    logic                          valid;
    logic                          ready;
    logic [ces_pkg::ROW_W-1:0]     row_index;
    logic [ces_pkg::RANK_W-1:0]    pick_rank;
    logic [ces_pkg::FEAT_W-1:0]    feature_index;
    logic                          from_smallest;
    logic                          last_pick;

    modport source (output valid, output row_index, output pick_rank,
                    output feature_index, output from_smallest, output last_pick,
                    input ready);
    modport sink   (input valid, input row_index, input pick_rank,
                    input feature_index, input from_smallest, input last_pick,
                    output ready);
endinterface
`default_nettype wire

[rtl/core/ces_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_dp
// datapath: config, score store, taken mask, quota divider, column scan
// ----------------------------------------------------------------------------
module ces_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [ces_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [ces_pkg::CFG_W-1:0]          i_cfg_data,
    input  ces_pkg::t_dp_cmd                  i_cmd,
    output ces_pkg::t_dp_stat                 o_stat,
    ces_score_if.sink                         i_score_ch,
    ces_pick_if.source                        o_pick_ch
);
    import ces_pkg::*;

    // configuration
    logic [CFG_W-1:0]    r_cfg_rows;
    logic [FEATS_W-1:0]  r_cfg_feats;
    logic [SEL_W-1:0]    r_cfg_budget;

    // memories
    t_score              r_score_mem [1<<ADDR_W];
    logic                r_mask_mem  [MAX_ROWS];
    logic [ROW_W-1:0]    r_list_mem  [MAX_SELECT];

    // load and selection state
    logic [ADDR_W-1:0]   r_load_cnt;
    logic [ROW_W-1:0]    r_clr_idx;
    logic [ROWS_W-1:0]   r_rows;
    logic [FEATS_W-1:0]  r_feats;
    logic [SEL_W-1:0]    r_c, r_rem, r_q, r_u, r_picked, r_n;
    logic [FEAT_W-1:0]   r_col;
    logic                r_ph;
    logic [ADDR_W-1:0]   r_base;

    // scan pipeline
    logic [ROWS_W-1:0]   r_row_i;
    logic                r_rd_v;
    logic [ROW_W-1:0]    r_rd_row;
    t_score              r_sc_q;
    logic                r_mk_q;
    logic                r_have;
    logic [ROW_W-1:0]    r_best;
    t_score              r_best_val;

    // undo sweep
    logic [SEL_W-1:0]    r_uk;
    logic                r_undo_v;
    logic [ROW_W-1:0]    r_list_q;

    // output register
    logic                r_out_v;
    logic [ROW_W-1:0]    r_out_row;
    logic [RANK_W-1:0]   r_out_rank;
    logic [FEAT_W-1:0]   r_out_feat;
    logic                r_out_small;
    logic                r_out_last;

    logic                accept, issue, better;
    logic [ROWS_W-1:0]   cur_rows;
    logic [FEATS_W-1:0]  cur_feats;
    logic [TOT_W-1:0]    total;
    logic [SEL_W-1:0]    bud_sat, c_val, two_f, q_fix;
    logic [12:0]         prod;
    logic [ADDR_W-1:0]   rd_addr;

    assign accept    = i_score_ch.valid && i_score_ch.ready;
    assign cur_rows  = clamp_rows(r_cfg_rows);
    assign cur_feats = clamp_feats(r_cfg_feats);
    assign total     = TOT_W'(cur_rows) * TOT_W'(cur_feats);
    assign bud_sat   = (r_cfg_budget > SEL_W'(MAX_SELECT)) ? SEL_W'(MAX_SELECT) : r_cfg_budget;
    assign c_val     = ({4'd0, bud_sat} > cur_rows) ? cur_rows[SEL_W-1:0] : bud_sat;
    assign two_f     = {1'b0, r_feats, 1'b0};
    assign q_fix     = (r_q == '0) ? SEL_W'(1) : r_q;
    assign prod      = 13'(two_f * q_fix);
    assign issue     = i_cmd.scan_step && (r_row_i < r_rows);
    assign rd_addr   = r_base + ADDR_W'(r_row_i[ROW_W-1:0]);
    assign better    = !r_have || (r_ph ? (r_sc_q < r_best_val) : (r_sc_q > r_best_val));

    assign i_score_ch.ready = i_cmd.load_en;

    assign o_stat.clr_last   = i_cmd.clr_step && (r_clr_idx == ROW_W'(MAX_ROWS - 1));
    assign o_stat.last_acc   = accept && ((TOT_W'(r_load_cnt) + TOT_W'(1)) >= total);
    assign o_stat.div_done   = r_rem < two_f;
    assign o_stat.sel_done   = r_picked == r_u;
    assign o_stat.phase_full = r_n == r_q;
    assign o_stat.scan_done  = (r_row_i == r_rows) && !r_rd_v;
    assign o_stat.out_busy   = r_out_v;
    assign o_stat.undo_done  = (r_uk == r_picked) && !r_undo_v;

    assign o_pick_ch.valid         = r_out_v;
    assign o_pick_ch.row_index     = r_out_row;
    assign o_pick_ch.pick_rank     = r_out_rank;
    assign o_pick_ch.feature_index = r_out_feat;
    assign o_pick_ch.from_smallest = r_out_small;
    assign o_pick_ch.last_pick     = r_out_last;

    // memories, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_score_mem[r_load_cnt] <= i_score_ch.score;
        end
        if (issue) begin
            r_sc_q <= r_score_mem[rd_addr];
            r_mk_q <= r_mask_mem[r_row_i[ROW_W-1:0]];
        end
        if (i_cmd.clr_step) begin
            r_mask_mem[r_clr_idx] <= 1'b0;
        end else if (i_cmd.pick) begin
            r_mask_mem[r_best] <= 1'b1;
        end else if (r_undo_v) begin
            r_mask_mem[r_list_q] <= 1'b0;
        end
        if (i_cmd.pick) begin
            r_list_mem[r_picked[RANK_W-1:0]] <= r_best;
        end
        if (i_cmd.undo_step && (r_uk < r_picked)) begin
            r_list_q <= r_list_mem[r_uk[RANK_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_rd_v && !r_mk_q && better) begin
            r_best     <= r_rd_row;
            r_best_val <= r_sc_q;
        end
        if (issue) begin
            r_rd_row <= r_row_i[ROW_W-1:0];
        end
        if (i_cmd.pick) begin
            r_out_row   <= r_best;
            r_out_rank  <= r_picked[RANK_W-1:0];
            r_out_feat  <= r_col;
            r_out_small <= r_ph;
            r_out_last  <= (r_picked + SEL_W'(1)) == r_u;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows   <= CFG_W'(MAX_ROWS);
            r_cfg_feats  <= FEATS_W'(1);
            r_cfg_budget <= SEL_W'(MAX_SELECT);
            r_load_cnt   <= '0;
            r_clr_idx    <= '0;
            r_rows       <= ROWS_W'(1);
            r_feats      <= FEATS_W'(1);
            r_c          <= '0;
            r_rem        <= '0;
            r_q          <= '0;
            r_u          <= '0;
            r_picked     <= '0;
            r_n          <= '0;
            r_col        <= '0;
            r_ph         <= 1'b0;
            r_base       <= '0;
            r_row_i      <= '0;
            r_rd_v       <= 1'b0;
            r_have       <= 1'b0;
            r_uk         <= '0;
            r_undo_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ROWS:     r_cfg_rows   <= i_cfg_data;
                    REG_FEATURES: r_cfg_feats  <= i_cfg_data[FEATS_W-1:0];
                    REG_BUDGET:   r_cfg_budget <= i_cfg_data[SEL_W-1:0];
                    default:      ;
                endcase
            end

            if (i_cmd.clr_step) begin
                r_clr_idx <= r_clr_idx + ROW_W'(1);
            end

            if (accept) begin
                if (o_stat.last_acc) begin
                    // latch the data set geometry for the selection run
                    r_load_cnt <= '0;
                    r_rows     <= cur_rows;
                    r_feats    <= cur_feats;
                    r_c        <= c_val;
                    r_rem      <= c_val;
                    r_q        <= '0;
                    r_picked   <= '0;
                    r_n        <= '0;
                    r_col      <= '0;
                    r_ph       <= 1'b0;
                    r_base     <= '0;
                end else begin
                    r_load_cnt <= r_load_cnt + ADDR_W'(1);
                end
            end

            if (i_cmd.div_step) begin
                r_rem <= r_rem - two_f;
                r_q   <= r_q + SEL_W'(1);
            end

            if (i_cmd.qfix) begin
                r_q <= q_fix;
                r_u <= (prod > 13'(r_c)) ? r_c : prod[SEL_W-1:0];
            end

            if (i_cmd.adv_phase) begin
                r_n <= '0;
                if (r_ph) begin
                    r_ph   <= 1'b0;
                    r_col  <= r_col + FEAT_W'(1);
                    r_base <= r_base + ADDR_W'(r_rows);
                end else begin
                    r_ph <= 1'b1;
                end
            end

            if (i_cmd.scan_start) begin
                r_row_i <= '0;
                r_rd_v  <= 1'b0;
                r_have  <= 1'b0;
            end else begin
                r_rd_v <= issue;
                if (issue) begin
                    r_row_i <= r_row_i + ROWS_W'(1);
                end
                if (r_rd_v && !r_mk_q) begin
                    r_have <= 1'b1;
                end
            end

            if (i_cmd.pick) begin
                r_out_v  <= 1'b1;
                r_picked <= r_picked + SEL_W'(1);
                r_n      <= r_n + SEL_W'(1);
            end else if (o_pick_ch.ready) begin
                r_out_v <= 1'b0;
            end

            if (i_cmd.undo_start) begin
                r_uk     <= '0;
                r_undo_v <= 1'b0;
            end else if (i_cmd.undo_step && (r_uk < r_picked)) begin
                r_uk     <= r_uk + SEL_W'(1);
                r_undo_v <= 1'b1;
            end else begin
                r_undo_v <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/ces_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ces_ctrl
// sequencer for mask clearing, loading, quota setup, picks and mask undo
// ----------------------------------------------------------------------------
module ces_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ces_pkg::t_dp_stat    i_stat,
    output ces_pkg::t_dp_cmd     o_cmd
);
    import ces_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_LOAD, S_DIV, S_QFIX, S_NEXT, S_SCAN, S_PICK, S_UNDO
    } t_state;

    t_state r_state, n_state;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_LOAD;
            end
            S_LOAD: begin
                cmd.load_en = 1'b1;
                if (i_stat.last_acc) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_QFIX;
                else cmd.div_step = 1'b1;
            end
            S_QFIX: begin
                cmd.qfix = 1'b1;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                if (i_stat.sel_done) begin
                    cmd.undo_start = 1'b1;
                    n_state        = S_UNDO;
                end else if (i_stat.phase_full) begin
                    cmd.adv_phase = 1'b1;
                end else begin
                    cmd.scan_start = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_stat.scan_done) n_state = S_PICK;
            end
            S_PICK: begin
                if (!i_stat.out_busy) begin
                    cmd.pick = 1'b1;
                    n_state  = S_NEXT;
                end
            end
            S_UNDO: begin
                cmd.undo_step = 1'b1;
                if (i_stat.undo_done) n_state = S_LOAD;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[rtl/core/column_extreme_subset_select.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_extreme_subset_select
// extreme-value row subset selection over a column-major score matrix
// ----------------------------------------------------------------------------
// load: one score item per cycle into the score store (single write port)
// selection after the last item: quota division by repeated subtraction, a quota fix,
//   then each pick takes one column scan through the store read port plus any
//   wait on the output item, with a phase change between phases; after the
//   picks, the taken mask is restored
// reset: synchronous; a clearing pass walks all 1024 entries of the taken mask
//   before the first item is taken, config writes are taken throughout
module column_extreme_subset_select (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [ces_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [ces_pkg::CFG_W-1:0]          i_cfg_data,
    ces_score_if.sink                         i_score_ch,
    ces_pick_if.source                        o_pick_ch
);
    import ces_pkg::*;

    // control path: controller issues commands, datapath answers with status
    t_dp_cmd  cmd;
    t_dp_stat stat;

    ces_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath holds config, the score store, the taken mask and the output item
    ces_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_score_ch (i_score_ch),
        .o_pick_ch  (o_pick_ch)
    );

endmodule
`default_nettype wire

[verif/column_extreme_subset_select_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_extreme_subset_select_test
// self-checking bench: loads score matrices under random stalls, predicts the
// selected rows per feature phase and compares every pick field by field
// ----------------------------------------------------------------------------
module column_extreme_subset_select_test;
    import ces_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0]  row_index;
        logic [RANK_W-1:0] pick_rank;
        logic [FEAT_W-1:0] feature_index;
        logic              from_smallest;
        logic              last_pick;
    } t_pick;

    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    ces_score_if score_ch ();
    ces_pick_if  pick_ch ();

    column_extreme_subset_select dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_score_ch (score_ch.source),
        .o_pick_ch  (pick_ch.sink)
    );

    // predictor copy of the block state
    t_score      matrix [MAX_ROWS*MAX_FEATURES];
    int          loaded;
    logic [CFG_W-1:0] cur_rows;
    logic [CFG_W-1:0] cur_feats;
    logic [CFG_W-1:0] cur_budget;

    t_pick expected_picks [$];
    int    mismatches;
    int    picks_seen;
    int    sets_done;
    longint cycles;

    // receiver control
    bit hold_off;       // long stall requested by a test
    bit no_idle;        // stretch with no idling on both sides

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[column_extreme_subset_select] ERROR");
            $finish;
        end
    end

    // work out the picks for one full data set
    task automatic select_extremes(input int rows, input int feats);
        bit   taken [MAX_ROWS];
        int   cap, quota, total, count, remain, best;
        bit   have;
        t_pick p;
        cap = (cur_budget > MAX_SELECT) ? MAX_SELECT : int'(cur_budget);
        if (cap == 0) return;
        if (cap > rows) cap = rows;
        quota = cap / (2 * feats);
        if (quota == 0) quota = 1;
        total = 2 * feats * quota;
        if (total > cap) total = cap;
        count = 0;
        for (int f = 0; f < feats && count < total; f++) begin
            for (int ph = 0; ph < 2 && count < total; ph++) begin
                remain = total - count;
                if (remain > quota) remain = quota;
                for (int n = 0; n < remain; n++) begin
                    have = 0;
                    best = 0;
                    for (int r = 0; r < rows; r++) begin
                        if (taken[r]) continue;
                        if (!have || (ph == 1 ? matrix[f*rows+r] < matrix[f*rows+best]
                                              : matrix[f*rows+r] > matrix[f*rows+best])) begin
                            have = 1;
                            best = r;
                        end
                    end
                    taken[best] = 1;
                    p.row_index     = ROW_W'(best);
                    p.pick_rank     = RANK_W'(count);
                    p.feature_index = FEAT_W'(f);
                    p.from_smallest = ph[0];
                    p.last_pick     = 1'b0;
                    expected_picks = {expected_picks, p};
                    count++;
                end
            end
        end
        expected_picks[expected_picks.size()-1].last_pick = 1'b1;
    endtask

    // predictor update for one accepted item
    task automatic take_score(input t_score s);
        int rows, feats;
        rows  = int'(clamp_rows(cur_rows));
        feats = int'(clamp_feats(cur_feats[FEATS_W-1:0]));
        matrix[loaded] = s;
        loaded++;
        if (loaded >= rows * feats) begin
            loaded = 0;
            sets_done++;
            select_extremes(rows, feats);
        end
    endtask

    // send one item, idling at random unless a no-idle stretch is on;
    // valid stays high after the item so that items can follow back to back
    task automatic send_score(input t_score s);
        if (!no_idle && $urandom_range(99) < 20) begin
            score_ch.valid <= 1'b0;
            do @(posedge i_clk); while (!no_idle && $urandom_range(99) < 20);
        end
        score_ch.valid <= 1'b1;
        score_ch.score <= s;
        do @(posedge i_clk); while (!score_ch.ready);
        take_score(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        if (idx == REG_ROWS) cur_rows = CFG_W'(value);
        else if (idx == REG_FEATURES) cur_feats = CFG_W'(value & 5'h1f);
        else cur_budget = CFG_W'(value & 7'h7f);
    endtask

    // wait for all picks plus the taken-mask restore tail
    task automatic drain();
        score_ch.valid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic configure(input int rows, input int feats, input int bud);
        drain();
        write_reg(REG_ROWS, rows);
        write_reg(REG_FEATURES, feats);
        write_reg(REG_BUDGET, bud);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_score random_score();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return t_score'($urandom_range(3)) - 1;   // small values, many ties
            default: return t_score'($urandom);
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++) send_score(random_score());
    endtask

    // receiver: random idling plus a hold-off requested by a test
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pick_ch.ready <= 1'b0;
        end else begin
            pick_ch.ready <= !hold_off && (no_idle || $urandom_range(99) >= 20);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_pick got, want;
        if (i_rst_n && pick_ch.valid && pick_ch.ready) begin
            got = {pick_ch.row_index, pick_ch.pick_rank, pick_ch.feature_index,
                   pick_ch.from_smallest, pick_ch.last_pick};
            picks_seen++;
            if (expected_picks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("pick mismatch: expected none got %p", got);
            end else begin
                want = expected_picks.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pick mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // extremes of the score field, ties and both phases on a tiny matrix
    task automatic test_directed();
        t_score vals [8];
        configure(4, 2, 4);
        vals = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 1, 1, 32'sh55555555};
        foreach (vals[i]) send_score(vals[i]);
        configure(3, 1, 3);
        send_score(32'shaaaaaaaa); send_score(5); send_score(5);
        // budget zero: data set completes without picks
        configure(2, 1, 0);
        send_set(2);
        // out-of-range registers: zero rows and features act as one, budget saturates
        configure(0, 0, 127);
        send_set(1);
        configure(1, 31, 1);
        send_set(16);
        // budget above rows clamps
        configure(5, 1, 64);
        send_set(5);
    endtask

    // widest budget with every rank, and the widest feature count
    task automatic test_max_sizes();
        configure(64, 1, 64);
        send_set(64);
        configure(2, 16, 64);
        send_set(32);
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        configure(8, 2, 16);
        hold_off = 1;
        fork
            send_set(48);
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
        join
        hold_off = 0;
        drain();
    endtask

    // random configurations with small matrices
    task automatic test_random();
        int rows, feats;
        for (int s = 0; s < 14; s++) begin
            rows  = $urandom_range(1, 12);
            feats = $urandom_range(1, 3);
            configure(rows, feats, $urandom_range(1, 64));
            no_idle = (s >= 4 && s < 9);
            send_set(rows * feats);
        end
        no_idle = 0;
    endtask

    initial begin
        cycles     = 0;
        mismatches = 0;
        picks_seen = 0;
        sets_done  = 0;
        loaded     = 0;
        hold_off   = 0;
        no_idle    = 0;
        cur_rows   = CFG_W'(1024);
        cur_feats  = CFG_W'(1);
        cur_budget = CFG_W'(64);
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_ROWS;
        i_cfg_data = '0;
        score_ch.valid = 1'b0;
        score_ch.score = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();
        test_max_sizes();
        drain();

        $display("covered %0d data sets and %0d picks, with stalls and register extremes",
                 sets_done, picks_seen);
        if (mismatches == 0 && expected_picks.size() == 0) begin
            $display("[column_extreme_subset_select] OK");
        end else begin
            $display("%0d mismatches, %0d picks missing", mismatches, expected_picks.size());
            $display("[column_extreme_subset_select] ERROR");
        end
        $finish;
    end
endmodule
